/* rtl/core/prcc_pkg.sv */
// Shared types, codes and tables for the palette RAM color converter.
package prcc_pkg;

    localparam int MAX_ENTRIES_DEF = 2048;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 24;
    localparam int DATA_W    = 16;
    localparam int ENTRY_W   = 11;
    localparam int CHAN_W    = 8;
    localparam int LEN_W     = 4;
    localparam int WORD_W    = 16;

    localparam logic [LEN_W-1:0] LENGTH_LOG2_RESET = 4'd11;

    localparam logic [OP_W-1:0] OP_BYTE_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_WORD_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_CONVERT    = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV,
        ST_MERGE
    } state_t;

    // floor(x * 255 / 31) for a 5-bit channel
    localparam logic [CHAN_W-1:0] SCALE5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

endpackage

/* rtl/core/prcc_ram.sv */
// Palette word memory: one write port, one registered read port.
module prcc_ram #(
    parameter int DEPTH = prcc_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [prcc_pkg::WORD_W-1:0] wdata,
    input  logic                        re,
    input  logic [AW-1:0]               raddr,
    output logic [prcc_pkg::WORD_W-1:0] rdata
);
    import prcc_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/prcc_conv.sv */
// Color expansion of one palette word into registered 8-bit channels.
module prcc_conv (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [prcc_pkg::WORD_W-1:0]  word,
    input  logic [prcc_pkg::ENTRY_W-1:0] idx,
    output logic                         result_valid,
    output logic [prcc_pkg::ENTRY_W-1:0] out_entry,
    output logic [prcc_pkg::CHAN_W-1:0]  red,
    output logic [prcc_pkg::CHAN_W-1:0]  green,
    output logic [prcc_pkg::CHAN_W-1:0]  blue
);
    import prcc_pkg::*;

    logic               valid_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  blue_reg;
    logic [4:0]         r5;
    logic [4:0]         g5;
    logic [4:0]         b5;

    // layout 0bgr BBBB GGGG RRRR: shadow bit becomes the channel LSB
    always_comb
    begin
        r5 = {word[3:0],  word[12]};
        g5 = {word[7:4],  word[13]};
        b5 = {word[11:8], word[14]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= idx;
            red_reg   <= SCALE5[r5];
            green_reg <= SCALE5[g5];
            blue_reg  <= SCALE5[b5];
        end
    end

    assign result_valid = valid_reg;
    assign out_entry    = entry_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

endmodule

/* rtl/core/palette_ram_color_convert.sv */
// Top level: palette RAM with byte/word writes and 8-bit color conversion.
//
//  port group        direction  handshake
//  start/op/...      in         accepted when start && !busy
//  result_valid/...  out        one-cycle strobe, no back-pressure
//  cfg_write/data    in         written on any edge with cfg_write high
//
// Word write and the unused op finish in ST_IDLE; byte write (read-modify-write)
// and convert pass through ST_MERGE or ST_CONV, since the read port of the memory
// is registered. A convert result appears in the cycle after ST_CONV. After reset
// a clearing pass writes zero to all MAX_ENTRIES words, one per cycle, with busy
// high throughout.
// The receiver cannot stall; results are never held.
module palette_ram_color_convert #(
    parameter int MAX_ENTRIES = prcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [prcc_pkg::OP_W-1:0]    op,
    input  logic [prcc_pkg::ADDR_W-1:0]  byte_address,
    input  logic [prcc_pkg::DATA_W-1:0]  write_data,
    input  logic [prcc_pkg::ENTRY_W-1:0] entry,
    input  logic                         cfg_write,
    input  logic [prcc_pkg::LEN_W-1:0]   cfg_data,
    output logic                         result_valid,
    output logic [prcc_pkg::ENTRY_W-1:0] out_entry,
    output logic [prcc_pkg::CHAN_W-1:0]  red,
    output logic [prcc_pkg::CHAN_W-1:0]  green,
    output logic [prcc_pkg::CHAN_W-1:0]  blue
);
    import prcc_pkg::*;

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int KMAX = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int EW   = (AW > ENTRY_W) ? AW : ENTRY_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [LEN_W-1:0]  length_log2_reg;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     clr_next;
    logic [AW-1:0]     addr_reg;
    logic [7:0]        byte_reg;
    logic              hi_reg;

    logic              accept;
    logic [LEN_W-1:0]  k;
    logic [AW-1:0]     mask;
    logic [AW-1:0]     word_idx;
    logic [AW-1:0]     conv_idx;
    logic [EW-1:0]     entry_wide;
    logic [EW-1:0]     conv_wide;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              conv_load;

    assign accept = start && !busy;

    // length saturates at the largest exponent that fits the memory
    always_comb
    begin
        k = (length_log2_reg > LEN_W'(KMAX)) ? LEN_W'(KMAX) : length_log2_reg;
        for (int i = 0; i < AW; i++)
        begin
            mask[i] = (LEN_W'(i) < k);
        end
        word_idx   = AW'(byte_address[ADDR_W-1:1]) & mask;
        entry_wide = EW'(entry);
        conv_idx   = AW'(entry_wide) & mask;
        conv_wide  = EW'(addr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            length_log2_reg <= LENGTH_LOG2_RESET;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_write)
            begin
                length_log2_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= (op == OP_CONVERT) ? conv_idx : word_idx;
            byte_reg <= write_data[7:0];
            hi_reg   <= ~byte_address[0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_CONVERT)
                    begin
                        state_next = ST_CONV;
                    end
                    else if (op == OP_BYTE_WRITE)
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_CONV:  state_next = ST_IDLE;
            ST_MERGE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = word_idx;
        ram_wdata = write_data;
        ram_re    = 1'b0;
        ram_raddr = word_idx;
        conv_load = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ram_we    = (op == OP_WORD_WRITE);
                    ram_re    = (op == OP_BYTE_WRITE) || (op == OP_CONVERT);
                    ram_raddr = (op == OP_CONVERT) ? conv_idx : word_idx;
                end
            end
            ST_CONV:
            begin
                conv_load = 1'b1;
            end
            ST_MERGE:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = hi_reg ? {byte_reg, ram_rdata[7:0]}
                                   : {ram_rdata[15:8], byte_reg};
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    prcc_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    prcc_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (conv_load),
        .word         (ram_rdata),
        .idx          (ENTRY_W'(conv_wide)),
        .result_valid (result_valid),
        .out_entry    (out_entry),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

endmodule

/* tb/tb.sv */
// Testbench for palette_ram_color_convert: directed and random palette traffic vs a predictor.

class palette_scoreboard;

    typedef struct {
        logic [prcc_pkg::ENTRY_W-1:0] ent;
        logic [prcc_pkg::CHAN_W-1:0]  red;
        logic [prcc_pkg::CHAN_W-1:0]  green;
        logic [prcc_pkg::CHAN_W-1:0]  blue;
    } color_t;

    logic [prcc_pkg::WORD_W-1:0] words [prcc_pkg::MAX_ENTRIES_DEF];
    logic [prcc_pkg::LEN_W-1:0]  len_log2;
    color_t                      colors_due [$];
    int                          errors;
    int                          conversions;
    int                          requests;

    function new();
        foreach (words[i])
            words[i] = '0;
        len_log2    = prcc_pkg::LENGTH_LOG2_RESET;
        errors      = 0;
        conversions = 0;
        requests    = 0;
    endfunction

    function void set_length(logic [prcc_pkg::LEN_W-1:0] v);
        len_log2 = v;
    endfunction

    function int pending();
        return colors_due.size();
    endfunction

    // exponent saturates at the largest power of two that fits the RAM
    function logic [prcc_pkg::ENTRY_W-1:0] entry_mask();
        int k;
        k = int'(len_log2);
        while (k > 0 && (1 << k) > prcc_pkg::MAX_ENTRIES_DEF)
            k--;
        return prcc_pkg::ENTRY_W'((1 << k) - 1);
    endfunction

    function logic [prcc_pkg::CHAN_W-1:0] widen(logic [4:0] c);
        return prcc_pkg::CHAN_W'((int'(c) * 255) / 31);
    endfunction

    function void note_request(logic [prcc_pkg::OP_W-1:0]    op,
                               logic [prcc_pkg::ADDR_W-1:0]  addr,
                               logic [prcc_pkg::DATA_W-1:0]  data,
                               logic [prcc_pkg::ENTRY_W-1:0] ent);
        logic [prcc_pkg::ENTRY_W-1:0] mask;
        logic [prcc_pkg::ENTRY_W:0]   b;
        logic [prcc_pkg::ENTRY_W-1:0] w;
        logic [prcc_pkg::WORD_W-1:0]  a;
        color_t                       c;
        mask = entry_mask();
        requests++;
        case (op)
            prcc_pkg::OP_BYTE_WRITE: begin
                // big-endian: even address lands in the high byte
                b = (addr[prcc_pkg::ENTRY_W:0] ^ (prcc_pkg::ENTRY_W+1)'(1)) & {mask, 1'b1};
                w = b[prcc_pkg::ENTRY_W:1];
                if (b[0])
                    words[w][15:8] = data[7:0];
                else
                    words[w][7:0] = data[7:0];
            end
            prcc_pkg::OP_WORD_WRITE: begin
                w = addr[prcc_pkg::ENTRY_W:1] & mask;
                words[w] = data;
            end
            prcc_pkg::OP_CONVERT: begin
                c.ent   = ent & mask;
                a       = words[c.ent];
                c.red   = widen({a[3:0], a[12]});
                c.green = widen({a[7:4], a[13]});
                c.blue  = widen({a[11:8], a[14]});
                colors_due.push_back(c);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [prcc_pkg::ENTRY_W-1:0] ent,
                               logic [prcc_pkg::CHAN_W-1:0]  red,
                               logic [prcc_pkg::CHAN_W-1:0]  green,
                               logic [prcc_pkg::CHAN_W-1:0]  blue);
        color_t c;
        if (colors_due.size() == 0) begin
            $error("unexpected result: entry %0d rgb %0d/%0d/%0d", ent, red, green, blue);
            errors++;
            return;
        end
        c = colors_due.pop_front();
        conversions++;
        if (ent !== c.ent) begin
            $error("out_entry: expected %0d, got %0d", c.ent, ent);
            errors++;
        end
        if (red !== c.red) begin
            $error("red: expected %0d, got %0d", c.red, red);
            errors++;
        end
        if (green !== c.green) begin
            $error("green: expected %0d, got %0d", c.green, green);
            errors++;
        end
        if (blue !== c.blue) begin
            $error("blue: expected %0d, got %0d", c.blue, blue);
            errors++;
        end
    endfunction

endclass

module tb;
    import prcc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 12000;
    localparam int ITEMS_PER_PHASE = 32;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   byte_address;
    logic [DATA_W-1:0]   write_data;
    logic [ENTRY_W-1:0]  entry;
    logic                cfg_write;
    logic [LEN_W-1:0]    cfg_data;
    logic                result_valid;
    logic [ENTRY_W-1:0]  out_entry;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;

    palette_scoreboard sb;
    int                settings_seen;

    palette_ram_color_convert dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .byte_address (byte_address),
        .write_data   (write_data),
        .entry        (entry),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .out_entry    (out_entry),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(out_entry, red, green, blue);
            if (cfg_write)
                sb.set_length(cfg_data);
            if (start && !busy)
                sb.note_request(op, byte_address, write_data, entry);
        end
    end

    // cycles with no request, result or register write
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || cfg_write)
                stall = 0;
            else
                stall++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // called at a falling edge; leaves start high after acceptance
    task automatic send(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                        input logic [DATA_W-1:0] d, input logic [ENTRY_W-1:0] e);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op           = o;
        byte_address = a;
        write_data   = d;
        entry        = e;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // hold off until every convert has reported and writes have settled
    task automatic drain();
        start = 1'b0;
        while (sb.pending() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        drain();
        cfg_data  = v;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
        settings_seen++;
    endtask

    task automatic random_request();
        logic [OP_W-1:0]    o;
        logic [ADDR_W-1:0]  a;
        logic [ENTRY_W-1:0] e;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            o = OP_CONVERT;
        else if (pick < 70)
            o = OP_WORD_WRITE;
        else if (pick < 95)
            o = OP_BYTE_WRITE;
        else
            o = OP_UNUSED;
        // keep most traffic on a few hot entries so reads hit fresh writes
        if ($urandom_range(0, 3) == 0)
        begin
            a = ADDR_W'($urandom());
            e = ENTRY_W'($urandom());
        end
        else
        begin
            a = ADDR_W'($urandom_range(0, 31));
            e = ENTRY_W'($urandom_range(0, 15));
        end
        send(o, a, DATA_W'($urandom()), e);
    endtask

    initial
    begin : stimulus
        logic [LEN_W-1:0] lengths [17];
        sb            = new();
        settings_seen = 0;
        lengths       = '{4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd10, 4'd12,
                          4'd15, 4'd7, 4'd4, 4'd9, 4'd6, 4'd13, 4'd14, 4'd11};
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_CONVERT;
        byte_address = '0;
        write_data   = '0;
        entry        = '0;
        cfg_write    = 1'b0;
        cfg_data     = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // wait out the clearing pass before the first register write
        set_length(4'd11);

        // cleared store, all-ones word, extremes of address and entry
        send(OP_CONVERT, 24'd0, 16'hFFFF, 11'd0);
        send(OP_CONVERT, 24'hFFFFFF, 16'h0000, 11'd2047);
        send(OP_WORD_WRITE, 24'd0, 16'h7FFF, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd0);
        send(OP_WORD_WRITE, 24'hFFFFFF, 16'hFFFF, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd2047);
        // byte halves: even address is the high byte, upper data bits ignored
        send(OP_BYTE_WRITE, 24'd2, 16'hFF5A, 11'd0);
        send(OP_BYTE_WRITE, 24'd3, 16'h00A5, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd1);
        // odd address on a word write names the same word
        send(OP_WORD_WRITE, 24'd5, 16'h1234, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd2);
        // each shadow bit on its own
        send(OP_WORD_WRITE, 24'd6, 16'h1000, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);
        send(OP_WORD_WRITE, 24'd6, 16'h2000, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);
        send(OP_WORD_WRITE, 24'd6, 16'h4000, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);
        send(OP_WORD_WRITE, 24'd6, 16'h8F0F, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);
        // unused op must leave the store alone
        send(OP_UNUSED, 24'd6, 16'hFFFF, 11'd3);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);
        // address above the palette wraps
        send(OP_BYTE_WRITE, 24'h800006, 16'h0077, 11'd0);
        send(OP_CONVERT, 24'd0, 16'd0, 11'd3);

        foreach (lengths[p])
        begin
            set_length(lengths[p]);
            repeat (ITEMS_PER_PHASE)
            begin
                random_request();
                if ($urandom_range(0, 19) == 0)
                    drain();
            end
        end

        drain();
        if (sb.pending() != 0)
        begin
            $error("%0d conversions never reported", sb.pending());
            sb.errors++;
        end
        $display("Ran %0d requests, %0d conversions checked, across %0d palette lengths.",
                 sb.requests, sb.conversions, settings_seen);
        $display("Covered byte/word writes, shadow bits, unused op and address wrap.");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/prcc_pkg.sv
rtl/core/prcc_ram.sv
rtl/core/prcc_conv.sv
rtl/core/palette_ram_color_convert.sv
tb/tb.sv
